/* hdl/vtcf_pkg.sv */
package vtcf_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_COPY  = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;

    // configuration register indexes
    localparam logic CFG_TEXTURE_PAGE  = 1'b0;
    localparam logic CFG_CLUT_POSITION = 1'b1;

    // texture page depth codes, bits 8:7 of the page word
    localparam logic [1:0] DEPTH_4BIT = 2'd0;
    localparam logic [1:0] DEPTH_8BIT = 2'd1;

    typedef enum logic [1:0] {
        ADDR_TEXEL,
        ADDR_CLUT,
        ADDR_SRC,
        ADDR_DEST
    } addr_sel_t;

    typedef struct packed {
        logic      latch_in;
        logic      load_addr;
        addr_sel_t addr_sel;
        logic      mem_rd;
        logic      mem_wr;
        logic      take_word;
        logic      take_colour;
        logic      load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       direct;
        logic       out_free;
    } dp_status_t;

endpackage

/* hdl/vram_texel_clut_fetch.sv */
// Texel fetch through a texture page and colour table out of a video store of
// STORE_WIDTH x STORE_HEIGHT 16-bit words held in one single-port memory.
// s_tuser carries the item kind: write word, copy word, or fetch texel; only a
// fetch gives a result on the m side. Items go one at a time: a new item is
// accepted only once the previous one is done, and a fetch waits in its result
// state while the previous result is not yet taken. The sequence follows from
// the single memory port (one read or write per cycle, registered read data),
// the registered address stage (row times width plus column) before each
// access, and the second, dependent read of the colour table for indexed
// texels. The store is not cleared at reset; contents of a cell never written
// are undefined. Configuration (texture page, colour table position) is written
// through cfg_wr_en/cfg_index/cfg_data; the user must do this only while idle,
// as the block itself does not enforce it.
module vram_texel_clut_fetch #(
    parameter int STORE_WIDTH  = 512,
    parameter int STORE_HEIGHT = 512,
    parameter int PAGE_SIZE    = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write: index 0 texture_page, index 1 clut_position
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // dest_x[8:0], dest_y[17:9], src_x[26:18], src_y[35:27], word_data[51:36],
    // u[59:52], v[67:60], zero fill [71:68]
    input  logic [71:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // texel_value[15:0], red[23:16], green[31:24], blue[39:32], alpha[47:40]
    output logic [47:0] m_tdata
);
    import vtcf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: one state per memory access and address load, plus idle, data and result states
    vtcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // store, coordinate math, texel extract and result register
    vtcf_datapath #(
        .STORE_WIDTH  (STORE_WIDTH),
        .STORE_HEIGHT (STORE_HEIGHT),
        .PAGE_SIZE    (PAGE_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* hdl/vtcf_ctrl.sv */
module vtcf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  vtcf_pkg::dp_status_t status,
    output vtcf_pkg::dp_cmd_t    cmd
);
    import vtcf_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADDR  = 4'd1;
    localparam logic [3:0] S_READ1 = 4'd2;
    localparam logic [3:0] S_DATA1 = 4'd3;
    localparam logic [3:0] S_CADDR = 4'd4;
    localparam logic [3:0] S_READ2 = 4'd5;
    localparam logic [3:0] S_DATA2 = 4'd6;
    localparam logic [3:0] S_DADDR = 4'd7;
    localparam logic [3:0] S_WRITE = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.addr_sel = ADDR_DEST;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_ADDR;
                end
            end
            S_ADDR:
            begin
                cmd.load_addr = 1'b1;
                unique case (status.op)
                    OP_WRITE:
                    begin
                        cmd.addr_sel = ADDR_DEST;
                        state_next   = S_WRITE;
                    end
                    OP_COPY:
                    begin
                        cmd.addr_sel = ADDR_SRC;
                        state_next   = S_READ1;
                    end
                    OP_FETCH:
                    begin
                        cmd.addr_sel = ADDR_TEXEL;
                        state_next   = S_READ1;
                    end
                    default:
                    begin
                        // unused kind: dropped without a result
                        cmd.load_addr = 1'b0;
                        state_next    = S_IDLE;
                    end
                endcase
            end
            S_READ1:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_DATA1;
            end
            S_DATA1:
            begin
                if (status.op == OP_COPY)
                begin
                    state_next = S_DADDR;
                end
                else
                begin
                    cmd.take_word = 1'b1;
                    state_next    = status.direct ? S_OUT : S_CADDR;
                end
            end
            S_CADDR:
            begin
                cmd.load_addr = 1'b1;
                cmd.addr_sel  = ADDR_CLUT;
                state_next    = S_READ2;
            end
            S_READ2:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_DATA2;
            end
            S_DATA2:
            begin
                cmd.take_colour = 1'b1;
                state_next      = S_OUT;
            end
            S_DADDR:
            begin
                cmd.load_addr = 1'b1;
                cmd.addr_sel  = ADDR_DEST;
                state_next    = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.mem_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/vtcf_datapath.sv */
module vtcf_datapath #(
    parameter int STORE_WIDTH  = 512,
    parameter int STORE_HEIGHT = 512,
    parameter int PAGE_SIZE    = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic [71:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  vtcf_pkg::dp_cmd_t    cmd,
    output vtcf_pkg::dp_status_t status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata
);
    import vtcf_pkg::*;

    localparam int DEPTH = STORE_WIDTH * STORE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    // column sums stay below STORE_WIDTH + 256
    localparam int WRAP_STEPS = (255 + STORE_WIDTH - 1) / STORE_WIDTH;
    localparam logic [AW-1:0] W_A = AW'(STORE_WIDTH);
    localparam logic [10:0]   W_X = 11'(STORE_WIDTH);
    localparam logic [10:0]   H_Y = 11'(STORE_HEIGHT);

    function automatic logic [10:0] wrap_x(input logic [10:0] val);
        logic [10:0] r;
        r = val;
        for (int i = 0; i < WRAP_STEPS; i++)
        begin
            if (r >= W_X)
            begin
                r = r - W_X;
            end
        end
        return r;
    endfunction

    // elaboration-time tables for the constant moduli
    logic [10:0] px_tab [32];
    logic [10:0] cx_tab [64];
    logic [7:0]  pmod_tab [256];

    for (genvar k = 0; k < 32; k++)
    begin : g_px
        localparam int PXV = (k * 64) % STORE_WIDTH;
        assign px_tab[k] = 11'(PXV);
    end
    for (genvar k = 0; k < 64; k++)
    begin : g_cx
        localparam int CXV = (k * 16) % STORE_WIDTH;
        assign cx_tab[k] = 11'(CXV);
    end
    for (genvar k = 0; k < 256; k++)
    begin : g_pm
        localparam int PMV = k % PAGE_SIZE;
        assign pmod_tab[k] = 8'(PMV);
    end

    // configuration
    logic [15:0] texture_page_reg;
    logic [15:0] clut_position_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texture_page_reg  <= '0;
            clut_position_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_TEXTURE_PAGE)
            begin
                texture_page_reg <= cfg_data;
            end
            else
            begin
                clut_position_reg <= cfg_data;
            end
        end
    end

    // latched item
    logic [1:0]  op_reg;
    logic [8:0]  dest_x_reg, dest_y_reg, src_x_reg, src_y_reg;
    logic [15:0] word_reg;
    logic [7:0]  u_reg, v_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg     <= s_tuser;
            dest_x_reg <= s_tdata[8:0];
            dest_y_reg <= s_tdata[17:9];
            src_x_reg  <= s_tdata[26:18];
            src_y_reg  <= s_tdata[35:27];
            word_reg   <= s_tdata[51:36];
            u_reg      <= pmod_tab[s_tdata[59:52]];
            v_reg      <= pmod_tab[s_tdata[67:60]];
        end
    end

    // texel and table coordinates
    logic [1:0]  depth;
    logic [7:0]  ux;
    logic [10:0] tx, cx;
    logic [9:0]  ty, cy;
    logic [15:0] texel_reg;
    logic [15:0] colour_reg;

    assign depth = texture_page_reg[8:7];
    assign ty    = {texture_page_reg[11], texture_page_reg[4], 8'h00} | {2'b00, v_reg};
    assign cy    = clut_position_reg[15:6];

    always_comb
    begin
        case (depth)
            DEPTH_4BIT: ux = {2'b00, u_reg[7:2]};
            DEPTH_8BIT: ux = {1'b0, u_reg[7:1]};
            default:    ux = u_reg;
        endcase
    end

    assign tx = wrap_x(px_tab[texture_page_reg[4:0]] + {3'b000, ux});
    assign cx = wrap_x(cx_tab[clut_position_reg[5:0]] + {3'b000, texel_reg[7:0]});

    // address stage
    logic [10:0]   sel_x;
    logic [9:0]    sel_y;
    logic          sel_oob;
    logic [AW-1:0] addr_reg;
    logic          addr_oob_reg;

    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_TEXEL:
            begin
                sel_x   = tx;
                sel_y   = ty;
                sel_oob = ({1'b0, ty} >= H_Y);
            end
            ADDR_CLUT:
            begin
                sel_x   = cx;
                sel_y   = cy;
                sel_oob = ({1'b0, cy} >= H_Y);
            end
            ADDR_SRC:
            begin
                sel_x   = {2'b00, src_x_reg};
                sel_y   = {1'b0, src_y_reg};
                sel_oob = ({2'b00, src_x_reg} >= W_X) || ({2'b00, src_y_reg} >= H_Y);
            end
            default:
            begin
                sel_x   = {2'b00, dest_x_reg};
                sel_y   = {1'b0, dest_y_reg};
                sel_oob = ({2'b00, dest_x_reg} >= W_X) || ({2'b00, dest_y_reg} >= H_Y);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_addr)
        begin
            addr_reg     <= AW'(sel_y) * W_A + AW'(sel_x);
            addr_oob_reg <= sel_oob;
        end
    end

    // video store, one port
    logic [15:0] store_mem [DEPTH];
    logic [15:0] rdata_reg;
    logic        rd_oob_reg;
    logic [15:0] rd_word;
    logic [15:0] wdata;

    assign rd_word = rd_oob_reg ? 16'h0000 : rdata_reg;
    assign wdata   = (op_reg == OP_WRITE) ? word_reg : rd_word;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && !addr_oob_reg)
        begin
            store_mem[addr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            rdata_reg  <= store_mem[addr_reg];
            rd_oob_reg <= addr_oob_reg;
        end
    end

    // texel extract
    logic [15:0] texel_next;

    always_comb
    begin
        case (depth)
            DEPTH_4BIT: texel_next = (rd_word >> {u_reg[1:0], 2'b00}) & 16'h000F;
            DEPTH_8BIT: texel_next = (rd_word >> {u_reg[0], 3'b000}) & 16'h00FF;
            default:    texel_next = rd_word;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_word)
        begin
            texel_reg  <= texel_next;
            colour_reg <= texel_next;
        end
        else if (cmd.take_colour)
        begin
            colour_reg <= rd_word;
        end
    end

    // result register
    logic        out_valid_reg;
    logic [47:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {
                (colour_reg != 16'h0000) ? 8'hFF : 8'h00,
                colour_reg[14:10], 3'b000,
                colour_reg[9:5], 3'b000,
                colour_reg[4:0], 3'b000,
                texel_reg
            };
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign status.op       = op_reg;
    assign status.direct   = depth[1];
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

/* hdl/vtcf_checker.sv */
module vtcf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous item in flight");

    // alpha is all zeros or all ones
    a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:40] == 8'h00 || m_tdata[47:40] == 8'hFF))
        else $error("alpha not 0 or 255");

    // zero alpha only with all colour channels zero, and channel low bits are clear
    a_alpha_colour: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[47:40] != 8'h00 || m_tdata[39:16] == 24'h000000)
                     && m_tdata[18:16] == 3'b000 && m_tdata[26:24] == 3'b000
                     && m_tdata[34:32] == 3'b000))
        else $error("colour channels inconsistent with alpha");

endmodule

bind vram_texel_clut_fetch vtcf_checker u_vtcf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
